// ----- design/days_to_hms_fraction_core_assert.svh -----
// assertion helpers for the days-to-hms core
`ifndef DAYS_TO_HMS_FRACTION_CORE_ASSERT_SVH
`define DAYS_TO_HMS_FRACTION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DHF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("dhf: same-cycle check failed");
// next-cycle implication
`define DHF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("dhf: next-cycle check failed");
`else
`define DHF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define DHF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- design/dhf_pkg.sv -----
`default_nettype none

package dhf_pkg;

  // field widths
  localparam int IN_W       = 56;
  localparam int FRAC_BITS  = 40;
  localparam int MAX_DIGITS = 9;
  localparam int HOURS_W    = 20;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int FRAC_W     = 30;
  localparam int RES_W      = 5;

  // apb
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-3:0] REG_RESOLUTION = '0;

  localparam int HOURS_MAX = 2**HOURS_W - 1;

  // internal widths
  localparam int P24_W  = IN_W + 5;
  localparam int HR_W   = P24_W - FRAC_BITS;
  localparam int HC_W   = HOURS_W + 1;
  localparam int HRX_W  = (HR_W > HC_W) ? HR_W : HC_W;
  localparam int FM_W   = FRAC_BITS + MIN_W;
  localparam int P6_W   = FRAC_BITS + 3;
  localparam int FL_W   = FRAC_BITS / 2;
  localparam int FH_W   = FRAC_BITS - FL_W;
  localparam int PLO_W  = FL_W + FRAC_W;
  localparam int PHI_W  = FH_W + FRAC_W;
  localparam int FSUM_W = FRAC_BITS + FRAC_W + 1;
  localparam int RCP_W  = 22;
  localparam int HQP_W  = HC_W + RCP_W;
  localparam int RND_W  = 3;

  // rounding modes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_FINE  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_S10   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_S60   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_S600  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_S3600 = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_H10   = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_H100  = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_H1000 = MODE_W'(7);

  // reciprocal division of the clipped hour count by 10, 100, 1000
  localparam logic [RCP_W-1:0] HQ_RCP10   = RCP_W'(1677722);
  localparam logic [RCP_W-1:0] HQ_RCP100  = RCP_W'(2684355);
  localparam logic [RCP_W-1:0] HQ_RCP1000 = RCP_W'(2147484);
  localparam int HQ_SH10   = 24;
  localparam int HQ_SH100  = 28;
  localparam int HQ_SH1000 = 31;

  localparam logic [FRAC_W-1:0] POW10 [0:9] = '{
    FRAC_W'(1), FRAC_W'(10), FRAC_W'(100), FRAC_W'(1000), FRAC_W'(10000),
    FRAC_W'(100000), FRAC_W'(1000000), FRAC_W'(10000000),
    FRAC_W'(100000000), FRAC_W'(1000000000)
  };

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FRAC_W-1:0] unit;
  } dhf_ctl_t;

  // coarse split of one item, carried down the pipe
  typedef struct packed {
    logic              neg;
    logic              big;
    logic [HC_W-1:0]   hc;
    logic              fhalf;
    logic [RND_W-1:0]  r600;
    logic [MIN_W-1:0]  min0;
    logic              fmhalf;
    logic [RND_W-1:0]  r10;
    logic [SEC_W-1:0]  sec0;
  } dhf_hms_t;

  typedef struct packed {
    dhf_hms_t             hms;
    logic [FRAC_BITS-1:0] fs;
    logic [HQP_W-1:0]     hq_p;
  } dhf_split_t;

endpackage

`default_nettype wire

// ----- design/dhf_if.sv -----
`default_nettype none

interface dhf_in_if import dhf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] days;

  modport source (output valid, output days, input ready);
  modport sink (input valid, input days, output ready);
endinterface

interface dhf_out_if import dhf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               negative;
  logic [HOURS_W-1:0] hours;
  logic [MIN_W-1:0]   minutes;
  logic [SEC_W-1:0]   seconds;
  logic [FRAC_W-1:0]  fraction;

  modport source (output valid, output negative, output hours, output minutes,
                  output seconds, output fraction, input ready);
  modport sink (input valid, input negative, input hours, input minutes,
                input seconds, input fraction, output ready);
endinterface

`default_nettype wire

// ----- design/dhf_cfg.sv -----
`default_nettype none

`include "days_to_hms_fraction_core_assert.svh"

module dhf_cfg import dhf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output dhf_ctl_t               ctl
);

  logic [RES_W-1:0] res_r;
  dhf_ctl_t         ctl_r;
  dhf_ctl_t         ctl_nxt;
  logic             hit;
  logic             wr;
  logic [RES_W-1:0] wval;
  logic [3:0]       digits;

  assign hit    = paddr[APB_AW-1:2] == REG_RESOLUTION;
  assign wr     = psel && penable && pwrite && pready && hit;
  assign wval   = pwdata[RES_W-1:0];
  assign pready = 1'b1;
  assign prdata = hit ? {{(APB_DW-RES_W){res_r[RES_W-1]}}, res_r} : '0;
  assign ctl    = ctl_r;

  // decode the resolution into a rounding mode and a fraction unit
  always_comb begin
    digits       = (wval[3:0] > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : wval[3:0];
    ctl_nxt.unit = FRAC_W'(1);
    ctl_nxt.mode = MODE_FINE;
    if (!wval[RES_W-1]) begin
      ctl_nxt.unit = POW10[digits];
    end else begin
      unique case (wval)
        5'b11111: ctl_nxt.mode = MODE_S10;
        5'b11110: ctl_nxt.mode = MODE_S60;
        5'b11101: ctl_nxt.mode = MODE_S600;
        5'b11100: ctl_nxt.mode = MODE_S3600;
        5'b11011: ctl_nxt.mode = MODE_H10;
        5'b11010: ctl_nxt.mode = MODE_H100;
        default:  ctl_nxt.mode = MODE_H1000;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= '0;
      ctl_r.mode <= MODE_FINE;
      ctl_r.unit <= FRAC_W'(1);
    end else if (wr) begin
      res_r <= wval;
      ctl_r <= ctl_nxt;
    end
  end

  `DHF_ASSERT_NXT(a_cfg_write, clk, rst_n, wr, res_r == $past(wval))

endmodule

`default_nettype wire

// ----- design/dhf_split.sv -----
`default_nettype none

`include "days_to_hms_fraction_core_assert.svh"

module dhf_split import dhf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  dhf_in_if.sink        in_ch,
  input  wire dhf_ctl_t ctl,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output dhf_split_t    dn_data
);

  localparam logic [P6_W-1:0] HALF6 = P6_W'(1) << (FRAC_BITS - 1);

  // stage valids and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic go1, go2, go3, go4;

  // stage 1: sign and magnitude
  logic            neg1_r, neg1_nxt;
  logic [IN_W-1:0] mag1_r, mag1_nxt;

  // stage 2: whole hours and hour fraction
  logic                 neg2_r;
  logic                 big2_r, big2_nxt;
  logic [HC_W-1:0]      hc2_r, hc2_nxt;
  logic [FRAC_BITS-1:0] fh2_r, fh2_nxt;
  logic [P24_W-1:0]     p24;
  logic [HRX_W-1:0]     hrx;

  // stage 3: minutes, minute fraction, ten-minute rounding, coarse hour offset
  dhf_hms_t             hms3_r, hms3_nxt;
  logic [FRAC_BITS-1:0] fm3_r, fm3_nxt;
  logic [HC_W-1:0]      hx3_r, hx3_nxt;
  logic [FM_W-1:0]      p60h;
  logic [P6_W-1:0]      p6h;
  logic [HC_W-1:0]      hoff;

  // stage 4: seconds, second fraction, ten-second rounding, reciprocal product
  dhf_split_t      s4_r, s4_nxt;
  logic [FM_W-1:0] p60m;
  logic [P6_W-1:0] p6m;
  logic [RCP_W-1:0] rcp;

  assign go4         = !v4_r || dn_ready;
  assign go3         = !v3_r || go4;
  assign go2         = !v2_r || go3;
  assign go1         = !v1_r || go2;
  assign in_ch.ready = go1;
  assign dn_valid    = v4_r;
  assign dn_data     = s4_r;

  always_comb begin
    neg1_nxt = in_ch.days[IN_W-1];
    mag1_nxt = neg1_nxt ? (~in_ch.days) + IN_W'(1) : in_ch.days;
  end

  always_comb begin
    p24      = (P24_W'(mag1_r) << 4) + (P24_W'(mag1_r) << 3);
    hrx      = HRX_W'(p24[P24_W-1:FRAC_BITS]);
    big2_nxt = hrx > HRX_W'(HOURS_MAX);
    hc2_nxt  = big2_nxt ? HC_W'(HOURS_MAX + 1) : hrx[HC_W-1:0];
    fh2_nxt  = p24[FRAC_BITS-1:0];
  end

  always_comb begin
    case (ctl.mode)
      MODE_H10:   hoff = HC_W'(5);
      MODE_H100:  hoff = HC_W'(50);
      MODE_H1000: hoff = HC_W'(500);
      default:    hoff = '0;
    endcase
    p60h            = (FM_W'(fh2_r) << 6) - (FM_W'(fh2_r) << 2);
    p6h             = (P6_W'(fh2_r) << 2) + (P6_W'(fh2_r) << 1) + HALF6;
    hms3_nxt        = '0;
    hms3_nxt.neg    = neg2_r;
    hms3_nxt.big    = big2_r;
    hms3_nxt.hc     = hc2_r;
    hms3_nxt.fhalf  = fh2_r[FRAC_BITS-1];
    hms3_nxt.r600   = p6h[P6_W-1:FRAC_BITS];
    hms3_nxt.min0   = p60h[FM_W-1:FRAC_BITS];
    fm3_nxt         = p60h[FRAC_BITS-1:0];
    hx3_nxt         = hc2_r + hoff;
  end

  always_comb begin
    case (ctl.mode)
      MODE_H10:   rcp = HQ_RCP10;
      MODE_H100:  rcp = HQ_RCP100;
      MODE_H1000: rcp = HQ_RCP1000;
      default:    rcp = '0;
    endcase
    p60m               = (FM_W'(fm3_r) << 6) - (FM_W'(fm3_r) << 2);
    p6m                = (P6_W'(fm3_r) << 2) + (P6_W'(fm3_r) << 1) + HALF6;
    s4_nxt.hms         = hms3_r;
    s4_nxt.hms.fmhalf  = fm3_r[FRAC_BITS-1];
    s4_nxt.hms.r10     = p6m[P6_W-1:FRAC_BITS];
    s4_nxt.hms.sec0    = p60m[FM_W-1:FRAC_BITS];
    s4_nxt.fs          = p60m[FRAC_BITS-1:0];
    s4_nxt.hq_p        = HQP_W'(hx3_r) * HQP_W'(rcp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go1) v1_r <= in_ch.valid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1 && in_ch.valid) begin
      neg1_r <= neg1_nxt;
      mag1_r <= mag1_nxt;
    end
    if (go2 && v1_r) begin
      neg2_r <= neg1_r;
      big2_r <= big2_nxt;
      hc2_r  <= hc2_nxt;
      fh2_r  <= fh2_nxt;
    end
    if (go3 && v2_r) begin
      hms3_r <= hms3_nxt;
      fm3_r  <= fm3_nxt;
      hx3_r  <= hx3_nxt;
    end
    if (go4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  `DHF_ASSERT_NXT(a_split_hold, clk, rst_n, v4_r && !dn_ready, v4_r)
  `DHF_ASSERT_NXT(a_split_fill, clk, rst_n, go1 && in_ch.valid, v1_r)

endmodule

`default_nettype wire

// ----- design/dhf_round.sv -----
`default_nettype none

`include "days_to_hms_fraction_core_assert.svh"

module dhf_round import dhf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dhf_ctl_t   ctl,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire dhf_split_t up_data,
  dhf_out_if.source       out_ch
);

  localparam logic [FSUM_W-1:0] HALF_S = FSUM_W'(1) << (FRAC_BITS - 1);

  logic v5_r, v6_r, ov_r;
  logic go5, go6, go7;

  // stage 5: fraction partial products, coarse hour quotient
  dhf_hms_t         hms5_r;
  logic [PLO_W-1:0] plo5_r, plo5_nxt;
  logic [PHI_W-1:0] phi5_r, phi5_nxt;
  logic [HC_W-1:0]  hq5_r, hq5_nxt;

  // stage 6: rounded fraction, coarse hours
  dhf_hms_t          hms6_r;
  logic [FRAC_W-1:0] fr6_r, fr6_nxt;
  logic [HC_W-1:0]   hco6_r, hco6_nxt;
  logic [FSUM_W-1:0] fsum;

  // stage 7: output register
  logic               oneg_r;
  logic [HOURS_W-1:0] ohours_r, ohours_nxt;
  logic [MIN_W-1:0]   omin_r, omin_nxt;
  logic [SEC_W-1:0]   osec_r, osec_nxt;
  logic [FRAC_W-1:0]  ofrac_r, ofrac_nxt;

  logic              fr_carry, s_carry, m_carry, sat;
  logic [SEC_W-1:0]  s_val;
  logic [MIN_W-1:0]  m_val;
  logic [HC_W-1:0]   h_val;
  logic [FRAC_W-1:0] f_val;

  assign go7             = !ov_r || out_ch.ready;
  assign go6             = !v6_r || go7;
  assign go5             = !v5_r || go6;
  assign up_ready        = go5;
  assign out_ch.valid    = ov_r;
  assign out_ch.negative = oneg_r;
  assign out_ch.hours    = ohours_r;
  assign out_ch.minutes  = omin_r;
  assign out_ch.seconds  = osec_r;
  assign out_ch.fraction = ofrac_r;

  always_comb begin
    plo5_nxt = PLO_W'(up_data.fs[FL_W-1:0]) * PLO_W'(ctl.unit);
    phi5_nxt = PHI_W'(up_data.fs[FRAC_BITS-1:FL_W]) * PHI_W'(ctl.unit);
    case (ctl.mode)
      MODE_H10:   hq5_nxt = HC_W'(up_data.hq_p >> HQ_SH10);
      MODE_H100:  hq5_nxt = HC_W'(up_data.hq_p >> HQ_SH100);
      MODE_H1000: hq5_nxt = HC_W'(up_data.hq_p >> HQ_SH1000);
      default:    hq5_nxt = '0;
    endcase
  end

  always_comb begin
    fsum    = (FSUM_W'(phi5_r) << FL_W) + FSUM_W'(plo5_r) + HALF_S;
    fr6_nxt = FRAC_W'(fsum >> FRAC_BITS);
    case (ctl.mode)
      MODE_H10:   hco6_nxt = (hq5_r << 3) + (hq5_r << 1);
      MODE_H100:  hco6_nxt = (hq5_r << 6) + (hq5_r << 5) + (hq5_r << 2);
      MODE_H1000: hco6_nxt = (hq5_r << 10) - (hq5_r << 4) - (hq5_r << 3);
      default:    hco6_nxt = '0;
    endcase
  end

  // rounding carries ripple into the hours; then saturate
  always_comb begin
    fr_carry = 1'b0;
    s_carry  = 1'b0;
    m_carry  = 1'b0;
    f_val    = '0;
    s_val    = '0;
    m_val    = '0;
    h_val    = hms6_r.hc;
    unique case (ctl.mode) inside
      MODE_FINE: begin
        fr_carry = fr6_r == ctl.unit;
        f_val    = fr_carry ? '0 : fr6_r;
        s_carry  = fr_carry && (hms6_r.sec0 == SEC_W'(59));
        s_val    = s_carry ? '0 : hms6_r.sec0 + SEC_W'(fr_carry);
        m_carry  = s_carry && (hms6_r.min0 == MIN_W'(59));
        m_val    = m_carry ? '0 : hms6_r.min0 + MIN_W'(s_carry);
        h_val    = hms6_r.hc + HC_W'(m_carry);
      end
      MODE_S10: begin
        s_carry = hms6_r.r10 == RND_W'(6);
        s_val   = s_carry ? '0 : (SEC_W'(hms6_r.r10) << 3) + (SEC_W'(hms6_r.r10) << 1);
        m_carry = s_carry && (hms6_r.min0 == MIN_W'(59));
        m_val   = m_carry ? '0 : hms6_r.min0 + MIN_W'(s_carry);
        h_val   = hms6_r.hc + HC_W'(m_carry);
      end
      MODE_S60: begin
        m_carry = hms6_r.fmhalf && (hms6_r.min0 == MIN_W'(59));
        m_val   = m_carry ? '0 : hms6_r.min0 + MIN_W'(hms6_r.fmhalf);
        h_val   = hms6_r.hc + HC_W'(m_carry);
      end
      MODE_S600: begin
        m_carry = hms6_r.r600 == RND_W'(6);
        m_val   = m_carry ? '0 : (MIN_W'(hms6_r.r600) << 3) + (MIN_W'(hms6_r.r600) << 1);
        h_val   = hms6_r.hc + HC_W'(m_carry);
      end
      MODE_S3600: begin
        h_val = hms6_r.hc + HC_W'(hms6_r.fhalf);
      end
      MODE_H10, MODE_H100, MODE_H1000: begin
        h_val = hco6_r;
      end
    endcase
    sat = hms6_r.big || (h_val > HC_W'(HOURS_MAX));
    if (sat) begin
      ohours_nxt = HOURS_W'(HOURS_MAX);
      omin_nxt   = MIN_W'(59);
      osec_nxt   = SEC_W'(59);
      ofrac_nxt  = ctl.unit - FRAC_W'(1);
    end else begin
      ohours_nxt = h_val[HOURS_W-1:0];
      omin_nxt   = m_val;
      osec_nxt   = s_val;
      ofrac_nxt  = f_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (go5) v5_r <= up_valid;
      if (go6) v6_r <= v5_r;
      if (go7) ov_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go5 && up_valid) begin
      hms5_r <= up_data.hms;
      plo5_r <= plo5_nxt;
      phi5_r <= phi5_nxt;
      hq5_r  <= hq5_nxt;
    end
    if (go6 && v5_r) begin
      hms6_r <= hms5_r;
      fr6_r  <= fr6_nxt;
      hco6_r <= hco6_nxt;
    end
    if (go7 && v6_r) begin
      oneg_r   <= hms6_r.neg;
      ohours_r <= ohours_nxt;
      omin_r   <= omin_nxt;
      osec_r   <= osec_nxt;
      ofrac_r  <= ofrac_nxt;
    end
  end

  `DHF_ASSERT_NXT(a_out_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r)
  `DHF_ASSERT_IMP(a_out_range, clk, rst_n, ov_r, (omin_r < MIN_W'(60)) && (osec_r < SEC_W'(60)))

endmodule

`default_nettype wire

// ----- design/days_to_hms_fraction_core.sv -----
// days to hours / minutes / seconds / decimal fraction converter
//
// in_ch carries a signed interval in days (56 bits, 40 fractional bits);
// out_ch returns the sign flag and the magnitude as hours (not wrapped at
// 24), minutes, seconds and a fraction of resolution_digits decimal places,
// rounded half away from zero. negative resolutions round the seconds to
// 10 s, 1 min, 10 min, 1 h, 10 h, 100 h or 1000 h and give a zero fraction
// both channels move one item per valid/ready transfer
// pipeline: seven register stages; an input transfer loads stage 1 and
//   the result is shown on out_ch from stage 7, the output register
// throughput: one item per cycle while out_ch does not stall; the stages
//   are sign and magnitude, hour split, minute split, second split,
//   fraction partial products, fraction rounding, carry and output
// when out_ch stalls, items keep moving into empty stages, so the core
//   still takes inputs until every stage is full; nothing is dropped
// reset (rst_n low at a clock edge) empties the pipeline and sets the
//   resolution register to 0 (whole seconds)
// resolution_digits sits at apb address 0 and may be written only while
//   no item is in flight
`default_nettype none

module days_to_hms_fraction_core import dhf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dhf_in_if.sink                 in_ch,
  dhf_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // decoded resolution shared by both halves of the pipe
  dhf_ctl_t   ctl;
  // handoff between the split stages and the rounding stages
  logic       mid_valid;
  logic       mid_ready;
  dhf_split_t mid_data;

  // configuration register and its decode
  dhf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  // stages 1-4: magnitude, hours, minutes, seconds, coarse hour reciprocal product
  dhf_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ctl      (ctl),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  // stages 5-7: decimal fraction, coarse hour quotient, rounding carries, saturation, output
  dhf_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid_data),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/sv/days_to_hms_fraction_core_tb.sv -----
`timescale 1ns / 1ps

module days_to_hms_fraction_core_tb;
  import dhf_pkg::*;

  // one converted interval as the block shows it on out_ch
  typedef struct packed {
    logic               negative;
    logic [HOURS_W-1:0] hours;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [FRAC_W-1:0]  fraction;
  } hms_t;

  // coarsest rounding the resolution register can ask for
  localparam int MIN_RES = -7;

  // rounding step in seconds for resolution 0, -1 .. -7
  localparam longint unsigned COARSE_STEP [0:7] = '{
    1, 10, 60, 600, 3600, 36000, 360000, 3600000
  };

  // zero, smallest steps, both range ends, one day, exact half-second ties
  localparam logic [IN_W-1:0] EDGE_DAYS [0:7] = '{
    '0,
    IN_W'(1),
    {IN_W{1'b1}},
    {1'b0, {(IN_W-1){1'b1}}},
    {1'b1, {(IN_W-1){1'b0}}},
    IN_W'(1) << FRAC_BITS,
    IN_W'(1) << 32,
    -(IN_W'(1) << 32)
  };

  // expected split of every accepted interval, oldest first
  class hms_scoreboard;
    logic signed [RES_W-1:0] resolution;
    hms_t expected_hms[$];
    int errors;

    function new();
      resolution = '0;
      errors = 0;
    endfunction

    // exact product with 86400 * 10^r (86400 alone for negative r), half-away rounding to the step, then field split
    function hms_t split_interval(logic [IN_W-1:0] d);
      hms_t conv;
      logic [IN_W-1:0] mag;
      logic [127:0] prod;
      int r;
      longint unsigned unit, step, total, hours, minutes, seconds, rem;
      bit sat;
      mag = d[IN_W-1] ? -d : d;
      r = int'(resolution);
      if (r > MAX_DIGITS) r = MAX_DIGITS;
      if (r < MIN_RES) r = MIN_RES;
      unit = 1;
      for (int i = 0; i < r; i++) unit = unit * 10;
      step = (r < 0) ? COARSE_STEP[-r] : 1;
      // half of the divisor 2^FRAC_BITS * step goes in before truncation
      prod = 128'(mag) * 128'(86400 * unit) + (128'(step) << (FRAC_BITS - 1));
      sat = (prod >> (64 + FRAC_BITS)) != 0;
      total = 64'(prod >> FRAC_BITS);
      total = (total / step) * step;
      hours = total / (3600 * unit);
      if (hours > HOURS_MAX) sat = 1'b1;
      conv.negative = d[IN_W-1];
      if (sat) begin
        conv.hours    = HOURS_W'(HOURS_MAX);
        conv.minutes  = MIN_W'(59);
        conv.seconds  = SEC_W'(59);
        conv.fraction = FRAC_W'(unit - 1);
      end else begin
        rem = total - hours * 3600 * unit;
        minutes = rem / (60 * unit);
        rem = rem - minutes * 60 * unit;
        seconds = rem / unit;
        conv.hours    = HOURS_W'(hours);
        conv.minutes  = MIN_W'(minutes);
        conv.seconds  = SEC_W'(seconds);
        conv.fraction = FRAC_W'(rem - seconds * unit);
      end
      return conv;
    endfunction

    function void note_days(logic [IN_W-1:0] d);
      expected_hms.push_back(split_interval(d));
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(hms_t got);
      hms_t want;
      if (expected_hms.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_hms.pop_front();
      if (got.negative !== want.negative)
        flag("negative", 64'(want.negative), 64'(got.negative));
      if (got.hours !== want.hours) flag("hours", 64'(want.hours), 64'(got.hours));
      if (got.minutes !== want.minutes)
        flag("minutes", 64'(want.minutes), 64'(got.minutes));
      if (got.seconds !== want.seconds)
        flag("seconds", 64'(want.seconds), 64'(got.seconds));
      if (got.fraction !== want.fraction)
        flag("fraction", 64'(want.fraction), 64'(got.fraction));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  // apb side of the resolution register
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dhf_in_if  in_bus ();
  dhf_out_if out_bus ();

  hms_scoreboard sb = new();

  // percent of cycles each side holds back
  int in_idle_pct;
  int out_idle_pct;

  hms_t seen_hms;

  days_to_hms_fraction_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // every result transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_hms.negative = out_bus.negative;
      seen_hms.hours    = out_bus.hours;
      seen_hms.minutes  = out_bus.minutes;
      seen_hms.seconds  = out_bus.seconds;
      seen_hms.fraction = out_bus.fraction;
      sb.check_result(seen_hms);
    end
  end

  // mix of full-range values, short intervals, tie-prone multiples of 2^-8 day
  // and values crowding both ends of the range
  function automatic logic [IN_W-1:0] rand_days();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      1: return IN_W'($signed(r[45:0]));
      2: return {r[23:0], 32'b0};
      3: return r[63] ? ({1'b1, {(IN_W-1){1'b0}}} + IN_W'(r[9:0]))
                      : ({1'b0, {(IN_W-1){1'b1}}} - IN_W'(r[9:0]));
      default: return r[IN_W-1:0];
    endcase
  endfunction

  // one interval transfer; called and returns at a falling edge
  task automatic send_days(input logic [IN_W-1:0] d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid = 1'b0;
      in_bus.days  = IN_W'({$urandom, $urandom});
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.days  = d;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_days(d);
    @(negedge clk);
  endtask

  // stop sending, let every outstanding result come back, then settle
  task automatic drain();
    in_bus.valid = 1'b0;
    while (sb.expected_hms.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // apb setup then access phase; only while the pipe is empty
  task automatic write_resolution(input logic signed [RES_W-1:0] r);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_RESOLUTION, 2'b00};
    pwdata  = APB_DW'(r);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.resolution = r;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    logic signed [RES_W-1:0] pick;
    in_bus.valid  = 1'b0;
    in_bus.days   = '0;
    out_bus.ready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_idle_pct   = 7;
    out_idle_pct  = 53;
    rst_n         = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // edge values at the reset resolution, the finest and the coarsest
    for (int i = 0; i < 3; i++) begin
      if (i == 1) write_resolution(RES_W'(MAX_DIGITS));
      if (i == 2) write_resolution(RES_W'(MIN_RES));
      foreach (EDGE_DAYS[j]) send_days(EDGE_DAYS[j]);
      drain();
    end

    // random bursts, each at its own resolution; every legal setting once,
    // then both register extremes (saturated), then any 5-bit value
    for (int c = 0; c < 30; c++) begin
      if (c < 10) begin
        in_idle_pct  = 7;
        out_idle_pct = 53;
      end else if (c < 20) begin
        in_idle_pct  = 53;
        out_idle_pct = 7;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (c < 17) pick = RES_W'((c * 5) % 17 + MIN_RES);
      else if (c == 17) pick = {1'b0, {(RES_W-1){1'b1}}};
      else if (c == 18) pick = {1'b1, {(RES_W-1){1'b0}}};
      else pick = RES_W'($urandom_range(31));
      write_resolution(pick);
      repeat (50) send_days(rand_days());
      drain();
    end

    if (sb.errors == 0 && sb.expected_hms.size() == 0) begin
      $display("PASS days_to_hms_fraction_core");
    end else begin
      $display("FAIL days_to_hms_fraction_core");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL days_to_hms_fraction_core");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/dhf_pkg.sv
design/dhf_if.sv
design/dhf_cfg.sv
design/dhf_split.sv
design/dhf_round.sv
design/days_to_hms_fraction_core.sv
tb/sv/days_to_hms_fraction_core_tb.sv
